// ----- src/qmm_pkg.sv -----
package qmm_pkg;
  localparam int WordW = 32;
  localparam int AddrW = 10;
  localparam int Depth = 1024;
  localparam int OpW = 4;
  localparam int QuadW = OpW + 3 * AddrW;
  localparam int LenW = 11;
  localparam logic [WordW-1:0] StringEnd = WordW'(34);

  localparam logic [1:0] CmdLoadProg = 2'd0;
  localparam logic [1:0] CmdLoadData = 2'd1;
  localparam logic [1:0] CmdStep     = 2'd2;
  localparam logic [1:0] CmdUnused   = 2'd3;

  localparam logic [OpW-1:0] OpNop = 4'd0, OpCopy = 4'd1, OpJeq = 4'd2, OpOutNum = 4'd3,
    OpIn = 4'd4, OpGoto = 4'd5, OpOutStr = 4'd6, OpRet = 4'd7, OpSub = 4'd8, OpAdd = 4'd9,
    OpDiv = 4'd10, OpMul = 4'd11, OpJgt = 4'd12, OpJlt = 4'd13, OpJle = 4'd14,
    OpJge = 4'd15;

  localparam logic [2:0] EvNone = 3'd0, EvNum = 3'd1, EvChar = 3'd2, EvHalt = 3'd3,
    EvDivZero = 3'd4;

  typedef struct packed {
    logic [2:0]       kind;
    logic [WordW-1:0] value;
    logic [AddrW-1:0] pc;
  } result_t;
endpackage

// ----- src/quad_memory_machine.sv -----
// Port   Dir | tuser, low bit up      | tdata, low bit up
// s_axis in  | opcode, quad_operation | address, quad_first, quad_second, quad_target, word_value
// m_axis out | event_kind             | out_value, program_counter, zero fill to 48 bits
// cfg    in  | none                   | cfg_wdata_i: program_length
// A load passes through StLoad and StOut from acceptance to result. A step reads the program
// word and up to three data words through the one data memory port, one read a cycle; a write
// back adds StWrite, the first step of a string StStr and StStrChk, and a divide StDiv, one
// quotient bit a cycle of the shift-subtract unit, and StDivFix. A step inside a string runs
// StStr and StStrChk. After reset a clearing pass zeroes all 1024 words of the data memory;
// no request is taken meanwhile. The output register holds a result until it is taken.
module quad_memory_machine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // address, quad_first, quad_second, quad_target, word_value
  input  logic [5:0]  s_axis_tuser,  // opcode, quad_operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // out_value, program_counter, zero fill
  output logic [2:0]  m_axis_tuser,  // event_kind
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i
);
  import qmm_pkg::*;

  localparam logic [3:0] StClear = 4'd0, StIdle = 4'd1, StLoad = 4'd2, StFetch = 4'd3,
    StRdA = 4'd4, StRdB = 4'd5, StRdT = 4'd6, StExec = 4'd7, StDiv = 4'd8,
    StDivFix = 4'd9, StWrite = 4'd10, StStr = 4'd11, StStrChk = 4'd12, StOut = 4'd13;

  logic [3:0] state_q, state_d;
  logic [QuadW-1:0] prog_mem [Depth];
  logic [WordW-1:0] data_mem [Depth];
  logic [QuadW-1:0] prog_rd_q;
  logic [WordW-1:0] data_rd_q;
  logic [AddrW-1:0] prog_wa;
  logic             prog_we;
  logic [AddrW-1:0] data_addr;
  logic             data_we;
  logic [WordW-1:0] data_wd;

  logic [1:0]       cmd_q;
  logic [AddrW-1:0] addr_q, f_q, s_q, g_q;
  logic [OpW-1:0]   qop_q;
  logic [WordW-1:0] word_q, a_q, b_q, res_q;
  logic [AddrW-1:0] pc_q, sp_q, clr_q;
  logic             halt_q, str_q;
  logic [LenW-1:0]  len_q;
  logic             out_v_q;
  result_t          out_q;

  logic [WordW-1:0] rem_q, quo_q, dvs_q;
  logic [5:0]       cnt_q;
  logic             neg_q;
  logic [WordW:0]   trial;

  logic [AddrW:0] pc_inc;
  assign pc_inc = {1'b0, pc_q} + 1'b1;

  assign s_axis_tready = (state_q == StIdle) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, out_q.pc, out_q.value};
  assign m_axis_tuser  = out_q.kind;

  always_ff @(posedge clk_i) begin
    if (prog_we) prog_mem[prog_wa] <= {qop_q, f_q, s_q, g_q};
    prog_rd_q <= prog_mem[pc_q];
  end
  always_ff @(posedge clk_i) begin
    if (data_we) data_mem[data_addr] <= data_wd;
    data_rd_q <= data_mem[data_addr];
  end

  assign prog_wa = addr_q;
  assign prog_we = (state_q == StLoad) && (cmd_q == CmdLoadProg);

  always_comb begin
    data_we = 1'b0;
    data_wd = res_q;
    data_addr = f_q;
    unique case (state_q)
      StClear: begin data_we = 1'b1; data_addr = clr_q; data_wd = '0; end
      StLoad: begin
        data_we = (cmd_q == CmdLoadData); data_addr = addr_q; data_wd = word_q;
      end
      StRdA, StFetch: data_addr = f_q;
      StRdB: data_addr = s_q;
      StRdT: data_addr = g_q;
      StWrite: begin
        data_we = 1'b1;
        data_addr = (qop_q == OpIn) ? f_q : g_q;
        data_wd = (qop_q == OpIn) ? word_q : res_q;
      end
      StStr, StStrChk: data_addr = sp_q;
      default: data_addr = f_q;
    endcase
  end

  assign trial = {rem_q, quo_q[WordW-1]} - {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == AddrW'(Depth - 1)) state_d = StIdle;
      StIdle:  if (s_axis_tvalid && s_axis_tready) state_d = StLoad;
      default: state_d = state_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      pc_q <= AddrW'(1);
      halt_q <= 1'b0;
      str_q <= 1'b0;
      sp_q <= '0;
      len_q <= LenW'(1);
      out_v_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) len_q <= cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          state_q <= state_d;
        end
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            cmd_q  <= s_axis_tuser[1:0];
            qop_q  <= s_axis_tuser[5:2];
            addr_q <= s_axis_tdata[9:0];
            f_q    <= s_axis_tdata[19:10];
            s_q    <= s_axis_tdata[29:20];
            g_q    <= s_axis_tdata[39:30];
            word_q <= s_axis_tdata[71:40];
            state_q <= state_d;
          end
        end
        StLoad: begin
          out_q.value <= '0;
          out_q.pc <= pc_q;
          if (cmd_q != CmdStep) begin
            out_q.kind <= EvNone; state_q <= StOut;
          end else if (halt_q) begin
            out_q.kind <= EvHalt; state_q <= StOut;
          end else if (str_q) begin
            out_q.kind <= EvNone; state_q <= StStr;
          end else if ({1'b0, pc_q} >= len_q) begin
            halt_q <= 1'b1; out_q.kind <= EvHalt; state_q <= StOut;
          end else begin
            out_q.kind <= EvNone; state_q <= StFetch;
          end
        end
        StFetch: begin
          qop_q <= prog_rd_q[QuadW-1 -: OpW];
          f_q <= prog_rd_q[3*AddrW-1 -: AddrW];
          s_q <= prog_rd_q[2*AddrW-1 -: AddrW];
          g_q <= prog_rd_q[AddrW-1:0];
          state_q <= StRdA;
        end
        StRdA: state_q <= StRdB;
        StRdB: begin a_q <= data_rd_q; state_q <= StRdT; end
        StRdT: begin b_q <= data_rd_q; state_q <= StExec; end
        StExec: begin : exec
          logic take;
          logic [WordW-1:0] tgt;
          logic adv;
          logic [3:0] nxt;
          take = 1'b0;
          tgt = data_rd_q;
          adv = 1'b1;
          nxt = StOut;
          unique case (qop_q)
            OpCopy: begin res_q <= a_q; nxt = StWrite; end
            OpJeq: take = (a_q == b_q);
            OpOutNum: begin out_q.kind <= EvNum; out_q.value <= a_q; end
            OpIn: nxt = StWrite;
            OpGoto: begin take = 1'b1; tgt = a_q; end
            OpOutStr: begin
              adv = 1'b0; str_q <= 1'b1; sp_q <= f_q + 1'b1;
              f_q <= f_q + 1'b1; nxt = StStr;
            end
            OpRet: begin adv = 1'b0; halt_q <= 1'b1; out_q.kind <= EvHalt; end
            OpSub: begin res_q <= a_q - b_q; nxt = StWrite; end
            OpAdd: begin res_q <= a_q + b_q; nxt = StWrite; end
            OpMul: begin res_q <= a_q * b_q; nxt = StWrite; end
            OpDiv: begin
              if (b_q == '0) begin
                res_q <= '0; out_q.kind <= EvDivZero; nxt = StWrite;
              end else begin
                quo_q <= a_q[WordW-1] ? -a_q : a_q;
                dvs_q <= b_q[WordW-1] ? -b_q : b_q;
                rem_q <= '0;
                neg_q <= a_q[WordW-1] ^ b_q[WordW-1];
                cnt_q <= 6'(WordW);
                adv = 1'b0;
                nxt = StDiv;
              end
            end
            OpJgt: take = ($signed(a_q) > $signed(b_q));
            OpJlt: take = ($signed(a_q) < $signed(b_q));
            OpJle: take = ($signed(a_q) <= $signed(b_q));
            OpJge: take = ($signed(a_q) >= $signed(b_q));
            default: take = 1'b0;
          endcase
          state_q <= nxt;
          if (take) begin
            pc_q <= tgt[AddrW-1:0]; out_q.pc <= tgt[AddrW-1:0];
          end else if (adv) begin
            pc_q <= pc_inc[AddrW-1:0]; out_q.pc <= pc_inc[AddrW-1:0];
            if (pc_inc[AddrW]) halt_q <= 1'b1;
          end
        end
        StDiv: begin
          if (!trial[WordW]) rem_q <= trial[WordW-1:0];
          else rem_q <= {rem_q[WordW-2:0], quo_q[WordW-1]};
          quo_q <= {quo_q[WordW-2:0], ~trial[WordW]};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd1) state_q <= StDivFix;
        end
        StDivFix: begin
          res_q <= neg_q ? -quo_q : quo_q;
          pc_q <= pc_inc[AddrW-1:0]; out_q.pc <= pc_inc[AddrW-1:0];
          if (pc_inc[AddrW]) halt_q <= 1'b1;
          state_q <= StWrite;
        end
        StWrite: state_q <= StOut;
        StStr: state_q <= StStrChk;
        StStrChk: begin
          if (data_rd_q == StringEnd) begin
            str_q <= 1'b0;
            pc_q <= pc_inc[AddrW-1:0]; out_q.pc <= pc_inc[AddrW-1:0];
            if (pc_inc[AddrW]) halt_q <= 1'b1;
            out_q.kind <= EvNone;
          end else begin
            out_q.kind <= EvChar;
            out_q.value <= {{(WordW-8){1'b0}}, data_rd_q[7:0]};
            sp_q <= sp_q + 1'b1;
          end
          state_q <= StOut;
        end
        StOut: begin
          out_v_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- verif/quad_memory_machine_tb.sv -----
module quad_memory_machine_tb;
  import qmm_pkg::*;

  class qmm_scoreboard;
    result_t          expected_q[$];
    int               errors;
    logic [QuadW-1:0] prog[Depth];
    logic [WordW-1:0] dat[Depth];
    logic [AddrW-1:0] pc;
    logic [AddrW-1:0] sptr;
    logic [LenW-1:0]  plen;
    bit               halted;
    bit               str_on;

    function new();
      foreach (dat[i]) dat[i] = '0;
      pc = 1;
      sptr = 0;
      plen = 1;
      halted = 0;
      str_on = 0;
      errors = 0;
    endfunction

    function void bump_pc();
      if (pc == Depth - 1) begin
        pc = 0;
        halted = 1;
      end else begin
        pc = pc + 1'b1;
      end
    endfunction

    function logic [2:0] next_char(output logic [WordW-1:0] v);
      logic [WordW-1:0] c;
      c = dat[sptr];
      v = '0;
      if (c == StringEnd) begin
        str_on = 0;
        bump_pc();
        return EvNone;
      end
      v = {24'b0, c[7:0]};
      sptr = sptr + 1'b1;
      return EvChar;
    endfunction

    function logic [2:0] exec(logic [WordW-1:0] inw, output logic [WordW-1:0] v);
      logic [QuadW-1:0] q;
      logic [OpW-1:0]   op;
      logic [AddrW-1:0] f, s, g;
      logic [WordW-1:0] a, b, t;
      bit               take;
      v = '0;
      take = 0;
      if (halted) return EvHalt;
      if (str_on) return next_char(v);
      if (pc >= plen) begin
        halted = 1;
        return EvHalt;
      end
      q = prog[pc];
      op = q[33:30];
      f = q[29:20];
      s = q[19:10];
      g = q[9:0];
      a = dat[f];
      b = dat[s];
      t = dat[g];
      case (op)
        OpCopy: dat[g] = a;
        OpJeq: take = (a == b);
        OpOutNum: begin
          v = a;
          bump_pc();
          return EvNum;
        end
        OpIn: dat[f] = inw;
        OpGoto: begin
          take = 1;
          t = a;
        end
        OpOutStr: begin
          str_on = 1;
          sptr = f + 1'b1;
          return next_char(v);
        end
        OpRet: begin
          halted = 1;
          return EvHalt;
        end
        OpSub: dat[g] = a - b;
        OpAdd: dat[g] = a + b;
        OpDiv: begin
          if (b == 0) begin
            dat[g] = '0;
            bump_pc();
            return EvDivZero;
          end else if (b == '1) begin
            dat[g] = -a;
          end else begin
            dat[g] = $signed(a) / $signed(b);
          end
        end
        OpMul: dat[g] = a * b;
        OpJgt: take = ($signed(a) > $signed(b));
        OpJlt: take = ($signed(a) < $signed(b));
        OpJle: take = ($signed(a) <= $signed(b));
        OpJge: take = ($signed(a) >= $signed(b));
        default: ;
      endcase
      if (take) pc = t[AddrW-1:0];
      else bump_pc();
      return EvNone;
    endfunction

    function void note_request(logic [1:0] cmd, logic [OpW-1:0] op, logic [AddrW-1:0] addr,
                               logic [AddrW-1:0] f, logic [AddrW-1:0] s,
                               logic [AddrW-1:0] t, logic [WordW-1:0] w);
      result_t r;
      r.kind = EvNone;
      r.value = '0;
      if (cmd == CmdLoadProg) prog[addr] = {op, f, s, t};
      else if (cmd == CmdLoadData) dat[addr] = w;
      else if (cmd == CmdStep) r.kind = exec(w, r.value);
      r.pc = pc;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic [2:0] kind, logic [WordW-1:0] value,
                               logic [AddrW-1:0] rpc, logic [5:0] fill);
      result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d value %h pc %0d", $time, kind, value, rpc);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: event_kind expected %0d actual %0d", $time, e.kind, kind);
        errors++;
      end
      if (value !== e.value) begin
        $display("%0t: out_value expected %h actual %h", $time, e.value, value);
        errors++;
      end
      if (rpc !== e.pc) begin
        $display("%0t: program_counter expected %0d actual %0d", $time, e.pc, rpc);
        errors++;
      end
      if (fill !== 6'b0) begin
        $display("%0t: tdata fill expected 0 actual %h", $time, fill);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [5:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [10:0] cfg_wdata_i;

  qmm_scoreboard machine_sb = new();
  int burst_left;
  int stall_left;
  int stall_mode;

  quad_memory_machine i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_we_i,
    .cfg_wdata_i
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 3000000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    stall_left = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (stall_left % 5 != 0);
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      machine_sb.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[41:32],
                              m_axis_tdata[47:42]);
    end
  end

  task automatic send_request(logic [1:0] cmd, logic [OpW-1:0] op, logic [AddrW-1:0] addr,
                              logic [AddrW-1:0] f, logic [AddrW-1:0] s,
                              logic [AddrW-1:0] t, logic [WordW-1:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {w, t, s, f, addr};
    s_axis_tuser <= {op, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    machine_sb.note_request(cmd, op, addr, f, s, t, w);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (machine_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_length(logic [LenW-1:0] len);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    machine_sb.plen = len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [AddrW-1:0] rand_addr();
    if ($urandom_range(0, 4) != 0) return AddrW'($urandom_range(0, 63));
    return AddrW'($urandom_range(0, Depth - 1));
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return $urandom_range(0, Depth - 1);
    if (pick < 75) return $urandom;
    if (pick < 85) return StringEnd;
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  function automatic logic [OpW-1:0] rand_op();
    logic [OpW-1:0] op;
    op = OpW'($urandom_range(0, 15));
    return (op == OpRet) ? OpNop : op;
  endfunction

  task automatic load_prog(logic [AddrW-1:0] addr, logic [OpW-1:0] op, logic [AddrW-1:0] f,
                           logic [AddrW-1:0] s, logic [AddrW-1:0] t);
    send_request(CmdLoadProg, op, addr, f, s, t, $urandom);
  endtask

  task automatic load_data(logic [AddrW-1:0] addr, logic [WordW-1:0] w);
    send_request(CmdLoadData, OpW'($urandom), addr, AddrW'($urandom), AddrW'($urandom),
                 AddrW'($urandom), w);
  endtask

  task automatic step(logic [WordW-1:0] w);
    send_request(CmdStep, OpW'($urandom), AddrW'($urandom), AddrW'($urandom),
                 AddrW'($urandom), AddrW'($urandom), w);
  endtask

  task automatic run_random(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) step(rand_word());
      else if (pick < 85) load_data(rand_addr(), rand_word());
      else if (pick < 95) begin
        load_prog(AddrW'($urandom), rand_op(), rand_addr(), rand_addr(), rand_addr());
      end else begin
        send_request(CmdUnused, OpW'($urandom), AddrW'($urandom), AddrW'($urandom),
                     AddrW'($urandom), AddrW'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    burst_left = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);

    // Every program word is written first so that no step can reach an unwritten one.
    for (int i = 0; i < Depth; i++) begin
      load_prog(AddrW'(i), rand_op(), rand_addr(), rand_addr(), rand_addr());
    end
    wait_idle();
    set_length(11'd1024);

    load_data(10, 32'h8000_0000);
    load_data(11, 32'hffff_ffff);
    load_data(20, 32'h0000_1248);
    load_data(21, 32'h0000_0169);
    load_data(22, StringEnd);
    load_data(15, 32'h1234_5c0b);
    load_data(16, 20);
    load_prog(1, OpDiv, 10, 11, 30);
    load_prog(2, OpDiv, 10, 12, 31);
    load_prog(3, OpOutNum, 30, 0, 0);
    load_prog(4, OpOutStr, 19, 0, 0);
    load_prog(5, OpIn, 40, 0, 0);
    load_prog(6, OpOutNum, 40, 0, 0);
    load_prog(7, OpOutStr, 21, 0, 0);
    load_prog(8, OpJge, 11, 12, 14);
    load_prog(9, OpGoto, 15, 0, 0);
    load_prog(11, OpMul, 10, 11, 32);
    load_prog(12, OpAdd, 10, 10, 33);
    load_prog(13, OpJlt, 11, 12, 16);
    repeat (15) step($urandom);
    wait_idle();

    run_random(330);
    wait_idle();
    set_length(LenW'($urandom_range(512, 1023)));
    run_random(330);
    wait_idle();

    if (!machine_sb.halted && !machine_sb.str_on) begin
      load_prog(machine_sb.pc, OpRet, rand_addr(), rand_addr(), rand_addr());
    end
    step($urandom);
    step($urandom);
    wait_idle();
    set_length(11'd2);
    run_random(20);
    wait_idle();
    set_length(11'd1);
    step($urandom);
    step($urandom);
    wait_idle();

    if (machine_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
